>>> rtl/tst_pkg.sv
package tst_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int PEND_W = 5;
   localparam int TIME_W = 48;
   localparam int ID_W = 32;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic [2:0] CMD_SCHED  = 3'd0;
   localparam logic [2:0] CMD_CANCEL = 3'd1;
   localparam logic [2:0] CMD_REMOVE = 3'd2;
   localparam logic [2:0] CMD_CANALL = 3'd3;
   localparam logic [2:0] CMD_TICK   = 3'd4;
   localparam logic [2:0] CMD_SETT   = 3'd5;
   localparam logic [2:0] CMD_QUERY  = 3'd6;
   localparam logic [2:0] CMD_STOP   = 3'd7;

   localparam logic [2:0] RSP_ID     = 3'd0;
   localparam logic [2:0] RSP_CB     = 3'd1;
   localparam logic [2:0] RSP_DEF    = 3'd2;
   localparam logic [2:0] RSP_DROP   = 3'd3;
   localparam logic [2:0] RSP_TICK   = 3'd4;
   localparam logic [2:0] RSP_QUERY  = 3'd5;
   localparam logic [2:0] RSP_REJECT = 3'd6;
   localparam logic [2:0] RSP_ACK    = 3'd7;

   // Values shared by every cell in the row.
   typedef struct packed {
      logic [ID_W-1:0]   key;
      logic [ID_W-1:0]   wr_ident;
      logic [TIME_W-1:0] wr_start;
      logic [TIME_W-1:0] wr_due;
      logic [31:0]       wr_delay;
      logic              wr_def;
      logic [TIME_W-1:0] tick_time;
      logic              mark_all;
      logic              clear_all;
   } cell_bcast_type;

   // Controls addressed to a single cell.
   typedef struct packed {
      logic wr;
      logic mark_can;
      logic mark_rem;
      logic fire_clr;
   } cell_sel_type;

   typedef struct packed {
      logic              valid;
      logic              fire;
      logic              match;
      logic              expired;
      logic              deferred;
      logic              cancelled;
      logic              removed;
      logic [ID_W-1:0]   ident;
      logic [31:0]       delay;
      logic [31:0]       elapsed;
   } cell_view_type;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [31:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {{(TIME_W - 31){1'b0}}, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

>>> rtl/tst_if.sv
interface tst_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] timer_id;
   logic [31:0] delay_ms;
   logic        handler_kind;
   logic [47:0] time_now;

   modport source (output valid, cmd, timer_id, delay_ms, handler_kind, time_now,
                   input ready);
   modport sink (input valid, cmd, timer_id, delay_ms, handler_kind, time_now,
                 output ready);
endinterface

interface tst_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] out_id;
   logic [31:0] elapsed_ms;
   logic [31:0] out_timeout;
   logic [4:0]  pending;
   logic        should_trigger;
   logic        last;

   modport source (output valid, kind, out_id, elapsed_ms, out_timeout, pending,
                   should_trigger, last, input ready);
   modport sink (input valid, kind, out_id, elapsed_ms, out_timeout, pending,
                 should_trigger, last, output ready);
endinterface

>>> rtl/tst_cell.sv
module tst_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  tst_pkg::cell_bcast_type       bcast,
   input  tst_pkg::cell_sel_type         sel,
   input  logic [tst_pkg::TIME_W-1:0]    min_in,
   input  logic [tst_pkg::CNT_W-1:0]     count_in,
   output logic [tst_pkg::TIME_W-1:0]    min_out,
   output logic [tst_pkg::CNT_W-1:0]     count_out,
   output tst_pkg::cell_view_type        view
);

   logic                          valid_ff;
   logic [tst_pkg::ID_W-1:0]      ident_ff;
   logic [tst_pkg::TIME_W-1:0]    start_ff;
   logic [tst_pkg::TIME_W-1:0]    due_ff;
   logic [31:0]                   delay_ff;
   logic                          def_ff;
   logic                          can_ff;
   logic                          rem_ff;
   logic [tst_pkg::TIME_W-1:0]    min_ff;
   logic [tst_pkg::CNT_W-1:0]     count_ff;
   logic [tst_pkg::TIME_W-1:0]    diff;
   logic                          expired;
   logic                          fire;
   logic                          survive;

   assign diff    = bcast.tick_time - start_ff;
   assign expired = diff >= {{(tst_pkg::TIME_W - 32){1'b0}}, delay_ff};
   assign fire    = valid_ff && (expired || can_ff);
   assign survive = valid_ff && !fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (bcast.clear_all || sel.fire_clr) begin
         valid_ff <= 1'b0;
      end else if (sel.wr) begin
         valid_ff <= 1'b1;
      end
      if (sel.wr) begin
         ident_ff <= bcast.wr_ident;
         start_ff <= bcast.wr_start;
         due_ff   <= bcast.wr_due;
         delay_ff <= bcast.wr_delay;
         def_ff   <= bcast.wr_def;
         can_ff   <= 1'b0;
         rem_ff   <= 1'b0;
      end else begin
         if (sel.mark_can || (bcast.mark_all && valid_ff)) begin
            can_ff <= 1'b1;
         end
         if (sel.mark_rem || (bcast.mark_all && valid_ff)) begin
            rem_ff <= 1'b1;
         end
      end
      // The running minimum and survivor count ripple one cell per cycle.
      min_ff   <= (survive && due_ff < min_in) ? due_ff : min_in;
      count_ff <= count_in + {{(tst_pkg::CNT_W - 1){1'b0}}, survive};
   end

   assign min_out   = min_ff;
   assign count_out = count_ff;

   always_comb begin
      view.valid     = valid_ff;
      view.fire      = fire;
      view.match     = valid_ff && (ident_ff == bcast.key);
      view.expired   = expired;
      view.deferred  = def_ff;
      view.cancelled = can_ff;
      view.removed   = rem_ff;
      view.ident     = ident_ff;
      view.delay     = delay_ff;
      view.elapsed   = diff[31:0];
   end

endmodule

>>> rtl/timer_slot_table.sv
// Table of SLOTS one-shot timers held in a row of cells, one timer per cell.
// A request is taken only while the block is idle. Schedule, cancel, remove,
// cancel-all, set-time, query and stop are accepted, decoded and give one response.
// A tick on a running table is accepted and decoded, then waits while the earliest
// due time and the survivor count ripple through the cell chain, then visits the
// cells in ascending order to send a response for each timer that fires, then
// sends the summary. A stalled response channel holds up the visit and the responses.
module timer_slot_table (
   input  logic       clock,
   input  logic       reset,
   tst_req_if.sink    req_ch,
   tst_rsp_if.source  rsp_ch
);

   typedef enum logic [2:0] {IDLE, EXEC, CHAIN, EMIT, SUMM} state_type;

   state_type                       state_ff;
   logic [2:0]                      cmd_ff;
   logic [31:0]                     tid_ff;
   logic [31:0]                     tmo_ff;
   logic                            hk_ff;
   logic [tst_pkg::TIME_W-1:0]      tnow_ff;
   logic [31:0]                     id_counter_ff;
   logic [tst_pkg::TIME_W-1:0]      cur_time_ff;
   logic [tst_pkg::TIME_W-1:0]      next_due_ff;
   logic                            running_ff;
   logic [tst_pkg::CNT_W-1:0]       count_ff;
   logic [tst_pkg::CNT_W-1:0]       wait_ff;
   logic [tst_pkg::IDX_W-1:0]       k_ff;

   logic                            out_valid_ff;
   logic [2:0]                      kind_ff;
   logic [31:0]                     out_id_ff;
   logic [31:0]                     elapsed_ff;
   logic [31:0]                     timeout_ff;
   logic [4:0]                      pending_ff;
   logic                            trig_ff;
   logic                            last_ff;

   tst_pkg::cell_bcast_type         bcast;
   tst_pkg::cell_sel_type           sel [tst_pkg::SLOTS];
   tst_pkg::cell_view_type          views [tst_pkg::SLOTS];
   logic [tst_pkg::TIME_W-1:0]      mins [tst_pkg::SLOTS+1];
   logic [tst_pkg::CNT_W-1:0]       counts [tst_pkg::SLOTS+1];
   logic [tst_pkg::SLOTS-1:0]       valid_vec;

   logic                            can_load;
   logic                            out_load;
   logic [31:0]                     id_new;
   logic                            any_free;
   logic                            any_match;
   logic [tst_pkg::IDX_W-1:0]       free_idx;
   logic [tst_pkg::IDX_W-1:0]       match_idx;
   logic [tst_pkg::TIME_W-1:0]      sched_due;
   tst_pkg::cell_view_type          cur;

   // Result of the single-response commands, built in EXEC.
   logic                            ex_load;
   logic                            ex_to_chain;
   logic [2:0]                      ex_kind;
   logic [31:0]                     ex_id;
   logic [tst_pkg::TIME_W-1:0]      ex_time;
   logic [tst_pkg::TIME_W-1:0]      ex_due;
   logic [tst_pkg::CNT_W-1:0]       ex_count;
   logic                            ex_trig;

   assign can_load     = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == IDLE);
   assign id_new       = id_counter_ff + 32'd1;
   assign sched_due    = tst_pkg::sat_add(cur_time_ff, tmo_ff);
   assign cur          = views[k_ff];
   assign out_load     = can_load && ((state_ff == EXEC && !ex_to_chain) ||
                                      (state_ff == EMIT && cur.fire) ||
                                      (state_ff == SUMM));

   assign mins[0]   = tst_pkg::TIME_MAX;
   assign counts[0] = '0;

   for (genvar i = 0; i < tst_pkg::SLOTS; i++) begin : g_cell
      tst_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .bcast     (bcast),
         .sel       (sel[i]),
         .min_in    (mins[i]),
         .count_in  (counts[i]),
         .min_out   (mins[i+1]),
         .count_out (counts[i+1]),
         .view      (views[i])
      );
      assign valid_vec[i] = views[i].valid;
   end

   always_comb begin
      any_free  = 1'b0;
      any_match = 1'b0;
      free_idx  = '0;
      match_idx = '0;
      for (int i = tst_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!views[i].valid) begin
            any_free = 1'b1;
            free_idx = tst_pkg::IDX_W'(i);
         end
         if (views[i].match) begin
            any_match = 1'b1;
            match_idx = tst_pkg::IDX_W'(i);
         end
      end
   end

   always_comb begin
      ex_load     = (state_ff == EXEC) && can_load;
      ex_to_chain = 1'b0;
      ex_kind     = tst_pkg::RSP_ACK;
      ex_id       = '0;
      ex_time     = cur_time_ff;
      ex_due      = next_due_ff;
      ex_count    = count_ff;

      bcast.key       = (cmd_ff == tst_pkg::CMD_SCHED) ? id_new : tid_ff;
      bcast.wr_ident  = id_new;
      bcast.wr_start  = cur_time_ff;
      bcast.wr_due    = sched_due;
      bcast.wr_delay  = tmo_ff;
      bcast.wr_def    = hk_ff;
      bcast.tick_time = tnow_ff;
      bcast.mark_all  = 1'b0;
      bcast.clear_all = 1'b0;
      for (int i = 0; i < tst_pkg::SLOTS; i++) begin
         sel[i] = '0;
      end

      unique case (cmd_ff)
         tst_pkg::CMD_SCHED: begin
            if (any_free) begin
               ex_kind = tst_pkg::RSP_ID;
               ex_id   = id_new;
               if (sched_due < next_due_ff) begin
                  ex_due = sched_due;
               end
               if (!any_match) begin
                  sel[free_idx].wr = ex_load;
                  ex_count         = count_ff + 1'b1;
               end
            end else begin
               ex_kind = tst_pkg::RSP_REJECT;
            end
         end
         tst_pkg::CMD_CANCEL, tst_pkg::CMD_REMOVE: begin
            ex_id = tid_ff;
            if (any_match) begin
               sel[match_idx].mark_can = ex_load;
               sel[match_idx].mark_rem = ex_load && (cmd_ff == tst_pkg::CMD_REMOVE);
            end
         end
         tst_pkg::CMD_CANALL: begin
            bcast.mark_all = ex_load;
         end
         tst_pkg::CMD_TICK: begin
            ex_kind = tst_pkg::RSP_TICK;
            if (running_ff) begin
               ex_to_chain = 1'b1;
               ex_time     = tnow_ff;
            end
         end
         tst_pkg::CMD_SETT: begin
            if (tnow_ff != '0) begin
               ex_time = tnow_ff;
            end
         end
         tst_pkg::CMD_QUERY: begin
            ex_kind = tst_pkg::RSP_QUERY;
         end
         tst_pkg::CMD_STOP: begin
            bcast.clear_all = ex_load;
            ex_count        = '0;
         end
         default: begin
            ex_kind = tst_pkg::RSP_ACK;
         end
      endcase

      ex_trig = (ex_count != '0) && (ex_time >= ex_due);

      if (state_ff == EMIT && can_load) begin
         sel[k_ff].fire_clr = cur.fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         cmd_ff  <= req_ch.cmd;
         tid_ff  <= req_ch.timer_id;
         tmo_ff  <= req_ch.delay_ms;
         hk_ff   <= req_ch.handler_kind;
         tnow_ff <= req_ch.time_now;
      end
      if (reset) begin
         state_ff      <= IDLE;
         id_counter_ff <= '0;
         cur_time_ff   <= '0;
         next_due_ff   <= tst_pkg::TIME_MAX;
         running_ff    <= 1'b1;
         count_ff      <= '0;
         wait_ff       <= '0;
         k_ff          <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ch.ready && !out_load) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_ch.valid) begin
                  state_ff <= EXEC;
               end
            end
            EXEC: begin
               if (can_load) begin
                  cur_time_ff <= ex_time;
                  if (cmd_ff == tst_pkg::CMD_SCHED && any_free) begin
                     id_counter_ff <= id_new;
                  end
                  if (cmd_ff == tst_pkg::CMD_STOP) begin
                     running_ff <= 1'b0;
                  end
                  if (ex_to_chain) begin
                     wait_ff  <= '0;
                     state_ff <= CHAIN;
                  end else begin
                     next_due_ff  <= ex_due;
                     count_ff     <= ex_count;
                     out_valid_ff <= 1'b1;
                     kind_ff      <= ex_kind;
                     out_id_ff    <= ex_id;
                     elapsed_ff   <= '0;
                     timeout_ff   <= '0;
                     pending_ff   <= 5'(ex_count);
                     trig_ff      <= ex_trig;
                     last_ff      <= 1'b1;
                     state_ff     <= IDLE;
                  end
               end
            end
            CHAIN: begin
               if (wait_ff == tst_pkg::CNT_W'(tst_pkg::SLOTS)) begin
                  next_due_ff <= mins[tst_pkg::SLOTS];
                  count_ff    <= counts[tst_pkg::SLOTS];
                  k_ff        <= '0;
                  state_ff    <= EMIT;
               end else begin
                  wait_ff <= wait_ff + 1'b1;
               end
            end
            EMIT: begin
               if (can_load) begin
                  if (cur.fire) begin
                     out_valid_ff <= 1'b1;
                     out_id_ff    <= cur.ident;
                     timeout_ff   <= cur.delay;
                     // Only a live callback that has not run out reports its elapsed time.
                     elapsed_ff   <= (!cur.deferred && !cur.removed && !cur.expired) ?
                                     cur.elapsed : '0;
                     pending_ff   <= 5'(count_ff);
                     trig_ff      <= (count_ff != '0) && (cur_time_ff >= next_due_ff);
                     last_ff      <= 1'b0;
                     if (!cur.deferred) begin
                        kind_ff <= cur.removed ? tst_pkg::RSP_DROP : tst_pkg::RSP_CB;
                     end else begin
                        kind_ff <= cur.cancelled ? tst_pkg::RSP_DROP : tst_pkg::RSP_DEF;
                     end
                  end
                  if (k_ff == tst_pkg::IDX_W'(tst_pkg::SLOTS - 1)) begin
                     state_ff <= SUMM;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end
            end
            SUMM: begin
               if (can_load) begin
                  out_valid_ff <= 1'b1;
                  kind_ff      <= tst_pkg::RSP_TICK;
                  out_id_ff    <= '0;
                  elapsed_ff   <= '0;
                  timeout_ff   <= '0;
                  pending_ff   <= 5'(count_ff);
                  trig_ff      <= (count_ff != '0) && (cur_time_ff >= next_due_ff);
                  last_ff      <= 1'b1;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.kind           = kind_ff;
   assign rsp_ch.out_id         = out_id_ff;
   assign rsp_ch.elapsed_ms     = elapsed_ff;
   assign rsp_ch.out_timeout    = timeout_ff;
   assign rsp_ch.pending        = pending_ff;
   assign rsp_ch.should_trigger = trig_ff;
   assign rsp_ch.last           = last_ff;

`ifndef ASSERT_OFF
   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == IDLE |-> count_ff == tst_pkg::CNT_W'($countones(valid_vec)))
      else $error("live count disagrees with slot valid bits");

   a_emit_only_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CHAIN || state_ff == EMIT) |-> running_ff)
      else $error("tick scan while stopped");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EXEC && can_load && cmd_ff == tst_pkg::CMD_STOP) |=> valid_vec == '0)
      else $error("stop left live slots");
`endif

endmodule

>>> tb/timer_slot_table_tb.sv
`timescale 1ns / 100ps

module timer_slot_table_tb;

   localparam int LIMIT = 5000000;
   localparam int N_RANDOM = 500;
   localparam int TAIL = 80;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] timer_id;
      logic [31:0] delay_ms;
      logic        handler_kind;
      logic [47:0] time_now;
   } request_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] out_id;
      logic [31:0] elapsed_ms;
      logic [31:0] out_timeout;
      logic [4:0]  pending;
      logic        should_trigger;
      logic        last;
   } result_type;

   // Directed row: a request plus an optional hand-typed single response.
   typedef struct {
      request_type req;
      bit          typed;
      logic [2:0]  kind;
      logic [31:0] out_id;
      logic [4:0]  pending;
      logic        trig;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tst_req_if req_ch ();
   tst_rsp_if rsp_ch ();

   timer_slot_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   // Shadow copy of the timer table.
   bit          tbl_valid [tst_pkg::SLOTS];
   logic [31:0] tbl_ident [tst_pkg::SLOTS];
   logic [47:0] tbl_start [tst_pkg::SLOTS];
   logic [31:0] tbl_delay [tst_pkg::SLOTS];
   bit          tbl_def [tst_pkg::SLOTS];
   bit          tbl_can [tst_pkg::SLOTS];
   bit          tbl_rem [tst_pkg::SLOTS];
   logic [31:0] id_count = '0;
   logic [47:0] now_ms = '0;
   logic [47:0] due_ms = tst_pkg::TIME_MAX;
   bit          is_running = 1'b1;

   result_type  pending_rsp [$];
   int          errors = 0;
   int          cycles = 0;
   int          sent = 0;
   int          rsp_seen = 0;
   int          fires_seen = 0;
   int          hold_asked = 0;
   bit          calm = 1'b0;
   logic [47:0] wall = '0;

   function automatic logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? tst_pkg::TIME_MAX : s[47:0];
   endfunction

   function automatic void timer_response(logic [2:0] kind, logic [31:0] ident,
                                          logic [31:0] el, logic [31:0] tmo, logic last);
      result_type r;
      r.kind = kind;
      r.out_id = ident;
      r.elapsed_ms = el;
      r.out_timeout = tmo;
      r.pending = '0;
      r.should_trigger = 1'b0;
      r.last = last;
      pending_rsp.push_back(r);
   endfunction

   // Applies one request to the shadow table and queues its responses.
   function automatic void predict_timers(request_type q);
      int first;
      int free_slot;
      int hit;
      int cnt;
      logic [47:0] diff;
      logic [47:0] d;
      bit expired;
      first = pending_rsp.size();
      free_slot = -1;
      hit = -1;
      case (q.cmd)
         tst_pkg::CMD_SCHED: begin
            for (int i = tst_pkg::SLOTS - 1; i >= 0; i--)
               if (!tbl_valid[i]) free_slot = i;
            if (free_slot < 0) begin
               timer_response(tst_pkg::RSP_REJECT, '0, '0, '0, 1'b1);
            end else begin
               id_count = id_count + 32'd1;
               for (int i = tst_pkg::SLOTS - 1; i >= 0; i--)
                  if (tbl_valid[i] && tbl_ident[i] == id_count) hit = i;
               if (hit < 0) begin
                  tbl_valid[free_slot] = 1'b1;
                  tbl_ident[free_slot] = id_count;
                  tbl_start[free_slot] = now_ms;
                  tbl_delay[free_slot] = q.delay_ms;
                  tbl_def[free_slot] = q.handler_kind;
                  tbl_can[free_slot] = 1'b0;
                  tbl_rem[free_slot] = 1'b0;
               end
               d = add_sat(now_ms, q.delay_ms);
               if (d < due_ms) due_ms = d;
               timer_response(tst_pkg::RSP_ID, id_count, '0, '0, 1'b1);
            end
         end
         tst_pkg::CMD_CANCEL, tst_pkg::CMD_REMOVE: begin
            for (int i = tst_pkg::SLOTS - 1; i >= 0; i--)
               if (tbl_valid[i] && tbl_ident[i] == q.timer_id) hit = i;
            if (hit >= 0) begin
               tbl_can[hit] = 1'b1;
               if (q.cmd == tst_pkg::CMD_REMOVE) tbl_rem[hit] = 1'b1;
            end
            timer_response(tst_pkg::RSP_ACK, q.timer_id, '0, '0, 1'b1);
         end
         tst_pkg::CMD_CANALL: begin
            for (int i = 0; i < tst_pkg::SLOTS; i++)
               if (tbl_valid[i]) begin
                  tbl_can[i] = 1'b1;
                  tbl_rem[i] = 1'b1;
               end
            timer_response(tst_pkg::RSP_ACK, '0, '0, '0, 1'b1);
         end
         tst_pkg::CMD_TICK: begin
            if (is_running) begin
               now_ms = q.time_now;
               for (int i = 0; i < tst_pkg::SLOTS; i++) begin
                  if (!tbl_valid[i]) continue;
                  diff = q.time_now - tbl_start[i];
                  expired = diff >= {16'd0, tbl_delay[i]};
                  if (!(expired || tbl_can[i])) continue;
                  tbl_valid[i] = 1'b0;
                  if (!tbl_def[i] && !tbl_rem[i])
                     timer_response(tst_pkg::RSP_CB, tbl_ident[i],
                                    expired ? 32'd0 : diff[31:0], tbl_delay[i], 1'b0);
                  else if (!tbl_def[i] || tbl_can[i])
                     timer_response(tst_pkg::RSP_DROP, tbl_ident[i], '0, tbl_delay[i], 1'b0);
                  else
                     timer_response(tst_pkg::RSP_DEF, tbl_ident[i], '0, tbl_delay[i], 1'b0);
               end
               due_ms = tst_pkg::TIME_MAX;
               for (int i = 0; i < tst_pkg::SLOTS; i++)
                  if (tbl_valid[i]) begin
                     d = add_sat(tbl_start[i], tbl_delay[i]);
                     if (d < due_ms) due_ms = d;
                  end
            end
            timer_response(tst_pkg::RSP_TICK, '0, '0, '0, 1'b1);
         end
         tst_pkg::CMD_SETT: begin
            if (q.time_now != '0) now_ms = q.time_now;
            timer_response(tst_pkg::RSP_ACK, '0, '0, '0, 1'b1);
         end
         tst_pkg::CMD_QUERY: timer_response(tst_pkg::RSP_QUERY, '0, '0, '0, 1'b1);
         default: begin
            for (int i = 0; i < tst_pkg::SLOTS; i++) tbl_valid[i] = 1'b0;
            is_running = 1'b0;
            timer_response(tst_pkg::RSP_ACK, '0, '0, '0, 1'b1);
         end
      endcase
      cnt = 0;
      for (int i = 0; i < tst_pkg::SLOTS; i++) cnt += tbl_valid[i];
      for (int k = first; k < pending_rsp.size(); k++) begin
         pending_rsp[k].pending = cnt[4:0];
         pending_rsp[k].should_trigger = (cnt > 0) && (now_ms >= due_ms);
      end
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      errors++;
      $display("MISMATCH @%0t response %0d: %s got 0x%0h expected 0x%0h",
               $realtime, rsp_seen, what, got, want);
   endtask

   task automatic send_request(request_type q, bit typed = 1'b0,
                               row_type row = '{default: '0});
      int gap;
      result_type t;
      gap = 0;
      if (!calm) gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.cmd <= q.cmd;
      req_ch.timer_id <= q.timer_id;
      req_ch.delay_ms <= q.delay_ms;
      req_ch.handler_kind <= q.handler_kind;
      req_ch.time_now <= q.time_now;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
      if (typed) begin
         // Keep the shadow state in step, but check against the typed response.
         predict_timers(q);
         void'(pending_rsp.pop_back());
         t.kind = row.kind;
         t.out_id = row.out_id;
         t.elapsed_ms = '0;
         t.out_timeout = '0;
         t.pending = row.pending;
         t.should_trigger = row.trig;
         t.last = 1'b1;
         pending_rsp.push_back(t);
      end else begin
         predict_timers(q);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
   endtask

   function automatic request_type mk(logic [2:0] cmd, logic [31:0] ident, logic [31:0] tmo,
                                      logic hk, logic [47:0] tn);
      request_type q;
      q.cmd = cmd;
      q.timer_id = ident;
      q.delay_ms = tmo;
      q.handler_kind = hk;
      q.time_now = tn;
      return q;
   endfunction

   function automatic row_type rw(request_type q, bit typed = 1'b0, logic [2:0] kind = '0,
                                  logic [31:0] ident = '0, logic [4:0] pend = '0,
                                  logic trig = 1'b0);
      row_type r;
      r.req = q;
      r.typed = typed;
      r.kind = kind;
      r.out_id = ident;
      r.pending = pend;
      r.trig = trig;
      return r;
   endfunction

   function automatic request_type random_request();
      request_type q;
      int pick;
      int live [$];
      q = mk(3'($urandom_range(0, 7)), $urandom(), $urandom_range(0, 200),
             1'($urandom_range(0, 1)), '0);
      if ($urandom_range(0, 9) == 0) q.delay_ms = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 35) q.cmd = tst_pkg::CMD_SCHED;
      else if (pick < 45) q.cmd = tst_pkg::CMD_CANCEL;
      else if (pick < 55) q.cmd = tst_pkg::CMD_REMOVE;
      else if (pick < 58) q.cmd = tst_pkg::CMD_CANALL;
      else if (pick < 85) q.cmd = tst_pkg::CMD_TICK;
      else if (pick < 93) q.cmd = tst_pkg::CMD_SETT;
      else q.cmd = tst_pkg::CMD_QUERY;
      if (q.cmd == tst_pkg::CMD_CANCEL || q.cmd == tst_pkg::CMD_REMOVE) begin
         for (int i = 0; i < tst_pkg::SLOTS; i++) if (tbl_valid[i]) live.push_back(i);
         if (live.size() > 0 && $urandom_range(0, 9) < 8)
            q.timer_id = tbl_ident[live[$urandom_range(0, live.size() - 1)]];
      end
      // Time mostly moves forward in small steps, now and then it jumps anywhere.
      wall = wall + $urandom_range(0, 120);
      q.time_now = wall;
      if ($urandom_range(0, 24) == 0) begin
         q.time_now = 48'({$urandom(), $urandom()});
         wall = q.time_now;
      end
      if (q.cmd == tst_pkg::CMD_SETT && $urandom_range(0, 7) == 0) q.time_now = '0;
      return q;
   endfunction

   // Response side: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin : rsp_side
      static int stall = 0;
      static int holds_done = 0;
      result_type got;
      result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.kind, rsp_ch.out_id, rsp_ch.elapsed_ms, rsp_ch.out_timeout,
                    rsp_ch.pending, rsp_ch.should_trigger, rsp_ch.last};
            rsp_seen++;
            if (got.kind == tst_pkg::RSP_CB || got.kind == tst_pkg::RSP_DEF ||
                got.kind == tst_pkg::RSP_DROP)
               fires_seen++;
            if (pending_rsp.size() == 0) begin
               errors++;
               $display("MISMATCH @%0t: response kind %0d with nothing expected",
                        $realtime, got.kind);
            end else begin
               want = pending_rsp[0];
               pending_rsp.delete(0);
               if (got.kind !== want.kind)
                  report_mismatch("kind", 48'(got.kind), 48'(want.kind));
               if (got.out_id !== want.out_id)
                  report_mismatch("out_id", 48'(got.out_id), 48'(want.out_id));
               if (got.elapsed_ms !== want.elapsed_ms)
                  report_mismatch("elapsed_ms", 48'(got.elapsed_ms), 48'(want.elapsed_ms));
               if (got.out_timeout !== want.out_timeout)
                  report_mismatch("out_timeout", 48'(got.out_timeout),
                                  48'(want.out_timeout));
               if (got.pending !== want.pending)
                  report_mismatch("pending", 48'(got.pending), 48'(want.pending));
               if (got.should_trigger !== want.should_trigger)
                  report_mismatch("should_trigger", 48'(got.should_trigger),
                                  48'(want.should_trigger));
               if (got.last !== want.last)
                  report_mismatch("last", 48'(got.last), 48'(want.last));
            end
         end
         if (holds_done < hold_asked) begin
            holds_done++;
            stall = 400;
         end
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               stall = ($urandom_range(0, 29) == 0) ? $urandom_range(15, 60)
                                                    : $urandom_range(1, 3);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding", cycles,
                  pending_rsp.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      row_type rows [$];
      request_type q;
      req_ch.valid = 1'b0;
      req_ch.cmd = tst_pkg::CMD_QUERY;
      req_ch.timer_id = '0;
      req_ch.delay_ms = '0;
      req_ch.handler_kind = 1'b0;
      req_ch.time_now = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      rows.push_back(rw(mk(tst_pkg::CMD_QUERY, '0, '0, 1'b0, '0), 1'b1,
                        tst_pkg::RSP_QUERY, '0, 5'd0, 1'b0));
      rows.push_back(rw(mk(tst_pkg::CMD_TICK, '0, '0, 1'b0, '0), 1'b1,
                        tst_pkg::RSP_TICK, '0, 5'd0, 1'b0));
      rows.push_back(rw(mk(tst_pkg::CMD_SCHED, '0, 32'd100, 1'b0, '0), 1'b1,
                        tst_pkg::RSP_ID, 32'd1, 5'd1, 1'b0));
      rows.push_back(rw(mk(tst_pkg::CMD_SCHED, '0, 32'd0, 1'b1, '0), 1'b1,
                        tst_pkg::RSP_ID, 32'd2, 5'd2, 1'b1));
      rows.push_back(rw(mk(tst_pkg::CMD_SCHED, '0, '1, 1'b0, '0), 1'b1,
                        tst_pkg::RSP_ID, 32'd3, 5'd3, 1'b1));
      rows.push_back(rw(mk(tst_pkg::CMD_SCHED, '0, 32'd50, 1'b1, '0), 1'b1,
                        tst_pkg::RSP_ID, 32'd4, 5'd4, 1'b1));
      rows.push_back(rw(mk(tst_pkg::CMD_CANCEL, 32'd1, '0, 1'b0, '0), 1'b1,
                        tst_pkg::RSP_ACK, 32'd1, 5'd4, 1'b1));
      rows.push_back(rw(mk(tst_pkg::CMD_REMOVE, 32'd4, '0, 1'b0, '0), 1'b1,
                        tst_pkg::RSP_ACK, 32'd4, 5'd4, 1'b1));
      rows.push_back(rw(mk(tst_pkg::CMD_CANCEL, '1, '0, 1'b0, '0), 1'b1,
                        tst_pkg::RSP_ACK, '1, 5'd4, 1'b1));
      rows.push_back(rw(mk(tst_pkg::CMD_SETT, '0, '0, 1'b0, '0), 1'b1,
                        tst_pkg::RSP_ACK, '0, 5'd4, 1'b1));
      rows.push_back(rw(mk(tst_pkg::CMD_SETT, '0, '0, 1'b0, 48'd30)));
      rows.push_back(rw(mk(tst_pkg::CMD_TICK, '0, '0, 1'b0, 48'd40)));
      rows.push_back(rw(mk(tst_pkg::CMD_SCHED, '0, 32'd10, 1'b0, '0)));
      rows.push_back(rw(mk(tst_pkg::CMD_SCHED, '0, 32'd10, 1'b1, '0)));
      rows.push_back(rw(mk(tst_pkg::CMD_REMOVE, 32'd3, '0, 1'b1, '0)));
      // A time behind the start wraps the elapsed count, so both fire as expired.
      rows.push_back(rw(mk(tst_pkg::CMD_TICK, '0, '0, 1'b0, 48'd20)));
      rows.push_back(rw(mk(tst_pkg::CMD_SETT, '0, '0, 1'b0, tst_pkg::TIME_MAX)));
      rows.push_back(rw(mk(tst_pkg::CMD_SCHED, '0, '1, 1'b1, '0)));
      rows.push_back(rw(mk(tst_pkg::CMD_SCHED, '0, 32'd5, 1'b0, '0)));
      rows.push_back(rw(mk(tst_pkg::CMD_QUERY, '1, '1, 1'b1, tst_pkg::TIME_MAX)));
      rows.push_back(rw(mk(tst_pkg::CMD_CANALL, '0, '0, 1'b0, '0)));
      rows.push_back(rw(mk(tst_pkg::CMD_TICK, '0, '0, 1'b0, tst_pkg::TIME_MAX)));
      foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i]);

      // Fill the table to the brim; the last schedule is turned away.
      for (int i = 0; i <= tst_pkg::SLOTS; i++)
         send_request(mk(tst_pkg::CMD_SCHED, '0, $urandom(), 1'($urandom_range(0, 1)), '0));
      send_request(mk(tst_pkg::CMD_CANALL, '0, '0, 1'b0, '0));
      send_request(mk(tst_pkg::CMD_TICK, '0, '0, 1'b0, '0));
      wait_drained();

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 150) hold_asked = 1;
         if (n == 300) wait_drained();
         calm = (n >= 400 && n < 450);
         q = random_request();
         send_request(q);
      end

      // Stop is final: the table never runs again after it.
      send_request(mk(tst_pkg::CMD_STOP, '0, '0, 1'b0, '0));
      send_request(mk(tst_pkg::CMD_TICK, '0, '0, 1'b0, tst_pkg::TIME_MAX));
      send_request(mk(tst_pkg::CMD_SCHED, '0, 32'd1, 1'b0, '0));
      send_request(mk(tst_pkg::CMD_CANCEL, id_count, '0, 1'b0, '0));
      send_request(mk(tst_pkg::CMD_SETT, '0, '0, 1'b0, 48'd7));
      send_request(mk(tst_pkg::CMD_QUERY, '0, '0, 1'b0, '0));
      wait_drained();

      $display("Sent %0d requests over %0d cycles; checked %0d responses, %0d of them fires.",
               sent, cycles, rsp_seen, fires_seen);
      $display("Covered a full table, marked and wrapped timers, stalls and a stopped table.");
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
